FILE: rtl/ihht_pkg.sv
// -----------------------------------------------------------------------------
// ihht_pkg
// Types and constants for the id handle hash table.
// -----------------------------------------------------------------------------
package ihht_pkg;

    typedef enum logic [2:0] {
        K_ALLOC_RANGE = 3'd0,
        K_ALLOC_EXACT = 3'd1,
        K_FIND        = 3'd2,
        K_REMOVE      = 3'd3,
        K_REPLACE     = 3'd4
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BOUND     = 3'd1,
        ST_LOAD      = 3'd2,
        ST_NO_FREE   = 3'd3,
        ST_INVALID   = 3'd4,
        ST_NOT_FOUND = 3'd5
    } t_status;

    localparam logic [1:0] SLOT_EMPTY = 2'd0;
    localparam logic [1:0] SLOT_LIVE  = 2'd1;
    localparam logic [1:0] SLOT_DEAD  = 2'd2;

    localparam logic [31:0] HASH_MUL = 32'd2654435761;
    localparam logic [31:0] ID_MAX   = 32'hFFFF_FFFF;
    localparam logic [31:0] ID_LAST  = 32'hFFFF_FFFE;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] id;
        logic [31:0] range_start;
        logic [31:0] range_end;
        logic [31:0] value;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] id_out;
        logic [31:0] value_out;
    } t_rsp;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_HASH,
        S_RD,
        S_WAIT,
        S_PROBE,
        S_NEXT_CAND,
        S_WRITE,
        S_CLEAR,
        S_DONE
    } t_state;

endpackage

FILE: rtl/ihht_ram.sv
// -----------------------------------------------------------------------------
// ihht_ram
// Generic single-port-write, single-port-read RAM with registered read.
// -----------------------------------------------------------------------------
module ihht_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: rtl/id_handle_hash_table.sv
// -----------------------------------------------------------------------------
// id_handle_hash_table
// Open addressing id-to-payload table, multiplicative hash, linear probing,
// tombstones on remove. One request in flight at a time.
// -----------------------------------------------------------------------------
//  channel | signals                   | direction | payload
//  request | i_req_valid / o_req_ready | in        | ihht_pkg::t_req
//  result  | o_rsp_valid / i_rsp_ready | out       | ihht_pkg::t_rsp
//
//  Probe walk: each slot passes RAM read, registered data and compare.
//  Accept to result handshake: decode, hash, walk, write; early rejects go
//  straight from decode to the result. Range alloc adds a next-candidate step,
//  hash and walk per taken candidate, and a free candidate is walked twice
//  (lookup, then insert). After reset a clearing pass marks every slot empty,
//  not ready meanwhile. The result waits in an output register; the block
//  stays busy until it is taken.
// -----------------------------------------------------------------------------
module id_handle_hash_table #(
    parameter int TABLE_SLOTS   = 64,
    parameter int PAYLOAD_WIDTH = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_req_valid,
    output logic            o_req_ready,
    input  ihht_pkg::t_req  i_req,
    output logic            o_rsp_valid,
    input  logic            i_rsp_ready,
    output ihht_pkg::t_rsp  o_rsp
);
    localparam int AW = $clog2(TABLE_SLOTS);
    localparam int CW = AW + 1;
    // insert refused when (live+1)*4 > slots*3
    localparam int LOAD_MAX = (TABLE_SLOTS * 3) / 4;

    // pending slot write
    localparam logic [1:0] W_NONE    = 2'd0;
    localparam logic [1:0] W_INSERT  = 2'd1;
    localparam logic [1:0] W_REMOVE  = 2'd2;
    localparam logic [1:0] W_REPLACE = 2'd3;

    ihht_pkg::t_state r_state, n_state;
    ihht_pkg::t_req   r_req;
    ihht_pkg::t_rsp   r_rsp;

    logic [CW-1:0]    r_live;
    logic [31:0]      r_hint;
    logic [AW-1:0]    r_idx;      // probe pointer / clear pointer
    logic [CW-1:0]    r_n;        // probes done on this walk
    logic [32:0]      r_cand;     // current candidate id (33b so it can pass last)
    logic [CW-1:0]    r_tries;    // candidates tried in range alloc
    logic [AW-1:0]    r_tomb;
    logic             r_tomb_ok;
    logic             r_bind;     // walk is the insert walk for the id being allocated
    logic [AW-1:0]    r_hit;
    logic [1:0]       r_wkind;    // W_NONE, W_INSERT, W_REMOVE, W_REPLACE

    logic [31:0]      w_id;
    logic [32:0]      w_last;
    logic [31:0]      w_prod;
    logic [1:0]       w_st;
    logic [31:0]      w_key;
    logic [PAYLOAD_WIDTH-1:0] w_pay;
    logic [PAYLOAD_WIDTH-1:0] w_val;

    // memory ports
    logic             st_we, kp_we;
    logic [AW-1:0]    st_wa, kp_wa;
    logic [1:0]       st_wd;
    logic [31:0]      k_wd;
    logic [PAYLOAD_WIDTH-1:0] p_wd;

    assign w_val  = PAYLOAD_WIDTH'(r_req.value);
    assign w_id   = (r_req.kind == ihht_pkg::K_ALLOC_RANGE) ? r_cand[31:0] : r_req.id;
    assign w_last = (r_req.range_end != 32'd0) ? {1'b0, r_req.range_end} - 33'd1
                                                : {1'b0, ihht_pkg::ID_LAST};
    assign w_prod = w_id * ihht_pkg::HASH_MUL;

    ihht_ram #(.WIDTH(2), .DEPTH(TABLE_SLOTS)) u_status (
        .i_clk(i_clk), .i_we(st_we), .i_waddr(st_wa), .i_wdata(st_wd),
        .i_raddr(r_idx), .o_rdata(w_st));
    ihht_ram #(.WIDTH(32), .DEPTH(TABLE_SLOTS)) u_key (
        .i_clk(i_clk), .i_we(kp_we), .i_waddr(kp_wa), .i_wdata(k_wd),
        .i_raddr(r_idx), .o_rdata(w_key));
    ihht_ram #(.WIDTH(PAYLOAD_WIDTH), .DEPTH(TABLE_SLOTS)) u_pay (
        .i_clk(i_clk), .i_we(kp_we), .i_waddr(kp_wa), .i_wdata(p_wd),
        .i_raddr(r_idx), .o_rdata(w_pay));

    logic w_empty, w_match, w_dead, w_walk_end;
    assign w_empty    = (w_st == ihht_pkg::SLOT_EMPTY);
    assign w_match    = (w_st == ihht_pkg::SLOT_LIVE) && (w_key == w_id);
    assign w_dead     = !w_empty && (w_st != ihht_pkg::SLOT_LIVE);
    assign w_walk_end = (r_n == CW'(TABLE_SLOTS - 1));

    // memory writes
    always_comb begin
        st_we = 1'b0; kp_we = 1'b0;
        st_wa = r_idx; kp_wa = r_hit;
        st_wd = ihht_pkg::SLOT_EMPTY;
        k_wd  = w_id;
        p_wd  = w_val;
        if (r_state == ihht_pkg::S_CLEAR) begin
            st_we = 1'b1;
        end else if (r_state == ihht_pkg::S_WRITE) begin
            st_wa = r_hit;
            case (r_wkind)
                W_INSERT: begin st_we = 1'b1; kp_we = 1'b1; st_wd = ihht_pkg::SLOT_LIVE; end
                W_REMOVE: begin st_we = 1'b1; kp_we = 1'b1; st_wd = ihht_pkg::SLOT_DEAD;
                            k_wd = r_req.id; p_wd = '0; end
                W_REPLACE: begin kp_we = 1'b1; k_wd = r_req.id; end
                default: ;
            endcase
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ihht_pkg::S_CLEAR:   if (r_idx == AW'(TABLE_SLOTS - 1)) n_state = ihht_pkg::S_IDLE;
            ihht_pkg::S_IDLE:    if (i_req_valid) n_state = ihht_pkg::S_DECODE;
            ihht_pkg::S_DECODE: begin
                n_state = ihht_pkg::S_HASH;
                if (r_req.kind > ihht_pkg::K_REPLACE) n_state = ihht_pkg::S_DONE;
                else if (r_req.kind != ihht_pkg::K_ALLOC_RANGE && r_req.id == 32'd0)
                    n_state = ihht_pkg::S_DONE;
                else if ((r_req.kind == ihht_pkg::K_ALLOC_RANGE ||
                          r_req.kind == ihht_pkg::K_ALLOC_EXACT) &&
                         int'(r_live) + 1 > LOAD_MAX)
                    n_state = ihht_pkg::S_DONE;
                else if (r_req.kind == ihht_pkg::K_ALLOC_RANGE && r_cand > w_last)
                    n_state = ihht_pkg::S_DONE;
            end
            ihht_pkg::S_HASH:    n_state = ihht_pkg::S_RD;
            ihht_pkg::S_RD:      n_state = ihht_pkg::S_WAIT;
            ihht_pkg::S_WAIT:    n_state = ihht_pkg::S_PROBE;
            ihht_pkg::S_PROBE: begin
                if (w_match) begin
                    if (r_req.kind == ihht_pkg::K_ALLOC_RANGE && !r_bind)
                        n_state = ihht_pkg::S_NEXT_CAND;
                    else n_state = ihht_pkg::S_WRITE;
                end else if (w_empty || w_walk_end) begin
                    if (r_req.kind == ihht_pkg::K_ALLOC_RANGE && !r_bind)
                        n_state = ihht_pkg::S_HASH; // free: restart as insert walk
                    else n_state = ihht_pkg::S_WRITE;
                end else n_state = ihht_pkg::S_RD;
            end
            ihht_pkg::S_NEXT_CAND: begin
                if (r_cand + 33'd1 > w_last || r_tries == CW'(TABLE_SLOTS))
                    n_state = ihht_pkg::S_DONE;
                else n_state = ihht_pkg::S_HASH;
            end
            ihht_pkg::S_WRITE:   n_state = ihht_pkg::S_DONE;
            ihht_pkg::S_DONE:    if (i_rsp_ready) n_state = ihht_pkg::S_IDLE;
            default:             n_state = ihht_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_req_ready = (r_state == ihht_pkg::S_IDLE);
        o_rsp_valid = (r_state == ihht_pkg::S_DONE);
        o_rsp       = r_rsp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ihht_pkg::S_CLEAR;
            r_idx   <= '0;
            r_live  <= '0;
            r_hint  <= 32'd1;
        end else begin
            r_state <= n_state;
            case (r_state)
                ihht_pkg::S_CLEAR: r_idx <= r_idx + AW'(1);
                ihht_pkg::S_IDLE: if (i_req_valid) begin
                    r_req <= i_req;
                    r_cand <= (i_req.range_start > r_hint) ? {1'b0, i_req.range_start}
                                                           : {1'b0, r_hint};
                    r_tries <= '0;
                    r_bind <= 1'b0;
                    r_wkind <= W_NONE;
                end
                ihht_pkg::S_DECODE: begin
                    r_rsp.id_out    <= '0;
                    r_rsp.value_out <= '0;
                    if (r_req.kind > ihht_pkg::K_REPLACE ||
                        (r_req.kind != ihht_pkg::K_ALLOC_RANGE && r_req.id == 32'd0))
                        r_rsp.status <= ihht_pkg::ST_INVALID;
                    else if ((r_req.kind == ihht_pkg::K_ALLOC_RANGE ||
                              r_req.kind == ihht_pkg::K_ALLOC_EXACT) &&
                             int'(r_live) + 1 > LOAD_MAX)
                        r_rsp.status <= ihht_pkg::ST_LOAD;
                    else if (r_req.kind == ihht_pkg::K_ALLOC_RANGE)
                        r_rsp.status <= ihht_pkg::ST_NO_FREE;
                    else if (r_req.kind == ihht_pkg::K_ALLOC_EXACT)
                        r_rsp.status <= ihht_pkg::ST_OK;
                    else r_rsp.status <= ihht_pkg::ST_NOT_FOUND;
                    if (r_req.kind == ihht_pkg::K_ALLOC_EXACT) r_bind <= 1'b1;
                end
                ihht_pkg::S_HASH: begin
                    r_idx     <= w_prod[AW-1:0];
                    r_n       <= '0;
                    r_tomb_ok <= 1'b0;
                end
                ihht_pkg::S_PROBE: begin
                    r_idx <= r_idx + AW'(1);
                    r_n   <= r_n + CW'(1);
                    if (w_dead && !r_tomb_ok) begin
                        r_tomb <= r_idx; r_tomb_ok <= 1'b1;
                    end
                    if (w_match) begin
                        r_hit <= r_idx;
                        if (r_bind) begin
                            r_rsp.status <= ihht_pkg::ST_BOUND;
                        end else if (r_req.kind != ihht_pkg::K_ALLOC_RANGE) begin
                            r_rsp.status    <= ihht_pkg::ST_OK;
                            r_rsp.value_out <= 32'(w_pay);
                            r_wkind <= (r_req.kind == ihht_pkg::K_REMOVE) ? W_REMOVE :
                                       (r_req.kind == ihht_pkg::K_REPLACE) ? W_REPLACE : W_NONE;
                        end
                    end else if (w_empty || w_walk_end) begin
                        if (r_req.kind == ihht_pkg::K_ALLOC_RANGE && !r_bind) begin
                            r_bind <= 1'b1;
                        end else if (r_bind) begin
                            if (r_tomb_ok || (w_dead && !r_tomb_ok)) begin
                                r_hit <= r_tomb_ok ? r_tomb : r_idx;
                                r_wkind <= W_INSERT; r_rsp.status <= ihht_pkg::ST_OK;
                            end else if (w_empty) begin
                                r_hit <= r_idx;
                                r_wkind <= W_INSERT; r_rsp.status <= ihht_pkg::ST_OK;
                            end else begin
                                r_rsp.status <= ihht_pkg::ST_LOAD;
                            end
                        end
                    end
                end
                ihht_pkg::S_NEXT_CAND: begin
                    r_cand  <= r_cand + 33'd1;
                    r_tries <= r_tries + CW'(1);
                end
                ihht_pkg::S_WRITE: begin
                    case (r_wkind)
                        W_INSERT: begin
                            r_live <= r_live + CW'(1);
                            if (r_req.kind == ihht_pkg::K_ALLOC_RANGE) begin
                                r_rsp.id_out <= r_cand[31:0];
                                if (r_hint <= r_cand[31:0])
                                    r_hint <= (r_cand[31:0] == ihht_pkg::ID_MAX)
                                              ? ihht_pkg::ID_MAX : r_cand[31:0] + 32'd1;
                            end
                        end
                        W_REMOVE: r_live <= r_live - CW'(1);
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
    end

    // live count never exceeds the load limit
    assert property (@(posedge i_clk) disable iff (!i_rst_n) int'(r_live) <= LOAD_MAX)
        else $error("live count over load limit");
    // result stays up until taken
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && !i_rsp_ready |=> o_rsp_valid && $stable(o_rsp))
        else $error("result dropped");
    // a nonzero id_out only comes with an ok status
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && o_rsp.id_out != 32'd0 |-> o_rsp.status == ihht_pkg::ST_OK)
        else $error("id_out without ok");
    // hint never falls to zero
    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_hint != 32'd0)
        else $error("hint zero");
endmodule

FILE: sim/id_handle_hash_table_test.sv
// -----------------------------------------------------------------------------
// id_handle_hash_table_test
// Self-checking bench for the id handle hash table: directed corner requests,
// then random request mixes, checked against an
// in-bench model of the probe table under random idling on both channels.
// -----------------------------------------------------------------------------
module id_handle_hash_table_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS     = 64;
    localparam int LIMIT_CYC = 80000000;
    localparam int HOLD_CYC  = 400;

    logic   clk;
    logic   rst_n;
    logic   req_valid = 1'b0;
    logic   req_ready;
    ihht_pkg::t_req req;
    logic   rsp_valid;
    logic   rsp_ready = 1'b0;
    ihht_pkg::t_rsp rsp;

    id_handle_hash_table u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_req_valid (req_valid),
        .o_req_ready (req_ready),
        .i_req       (req),
        .o_rsp_valid (rsp_valid),
        .i_rsp_ready (rsp_ready),
        .o_rsp       (rsp)
    );

    // Table model: slot state, keys, payloads, live count and alloc hint.
    logic [1:0]  tbl_state [SLOTS] = '{default: ihht_pkg::SLOT_EMPTY};
    logic [31:0] tbl_key   [SLOTS] = '{default: '0};
    logic [31:0] tbl_val   [SLOTS] = '{default: '0};
    int unsigned tbl_live   = 0;
    logic [31:0] alloc_hint = 32'd1;

    ihht_pkg::t_req pending_reqs [$];
    ihht_pkg::t_rsp expected_rsps [$];
    logic [31:0] bound_ids [$];   // ids believed bound, for steering stimulus
    int     errors    = 0;
    int     rsp_count = 0;
    int     cycles    = 0;
    int     req_idle_pct;
    int     rsp_idle_pct;
    bit     req_fire;             // request taken at the last rising edge
    bit     hold_go = 1'b0;       // starts the long receiver hold-off
    int     hold_cnt = 0;
    logic   hold_rsp;
    int     status_seen [8];

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic logic [5:0] home_of(logic [31:0] id);
        logic [31:0] prod;
        prod = id * ihht_pkg::HASH_MUL;
        return prod[5:0];
    endfunction

    function automatic int lookup_slot(logic [31:0] id);
        logic [5:0] idx;
        idx = home_of(id);
        for (int n = 0; n < SLOTS; n++) begin
            if (tbl_state[idx] == ihht_pkg::SLOT_EMPTY) return -1;
            if (tbl_state[idx] == ihht_pkg::SLOT_LIVE && tbl_key[idx] == id)
                return int'(idx);
            idx = idx + 6'd1;
        end
        return -1;
    endfunction

    function automatic bit load_full();
        return (tbl_live + 1) * 4 > SLOTS * 3;
    endfunction

    function automatic ihht_pkg::t_status insert_id(logic [31:0] id, logic [31:0] val);
        logic [5:0] idx;
        int         tomb;
        int         n;
        int         at;
        idx  = home_of(id);
        tomb = -1;
        for (n = 0; n < SLOTS; n++) begin
            if (tbl_state[idx] == ihht_pkg::SLOT_EMPTY) break;
            if (tbl_state[idx] == ihht_pkg::SLOT_LIVE) begin
                if (tbl_key[idx] == id) return ihht_pkg::ST_BOUND;
            end else if (tomb < 0) begin
                tomb = int'(idx);
            end
            idx = idx + 6'd1;
        end
        if (tomb >= 0) at = tomb;
        else if (n < SLOTS) at = int'(idx);
        else return ihht_pkg::ST_LOAD;
        tbl_state[at] = ihht_pkg::SLOT_LIVE;
        tbl_key[at]   = id;
        tbl_val[at]   = val;
        tbl_live++;
        return ihht_pkg::ST_OK;
    endfunction

    // Applies one request to the model and returns the expected response.
    function automatic ihht_pkg::t_rsp table_apply(ihht_pkg::t_req r);
        ihht_pkg::t_rsp o;
        logic [32:0] last;
        logic [32:0] cand;
        int          s;
        o = '{status: ihht_pkg::ST_INVALID, id_out: '0, value_out: '0};
        case (r.kind)
            ihht_pkg::K_ALLOC_RANGE: begin
                if (load_full()) begin
                    o.status = ihht_pkg::ST_LOAD;
                end else begin
                    last = (r.range_end != 0) ? {1'b0, r.range_end} - 33'd1
                                              : {1'b0, ihht_pkg::ID_LAST};
                    cand = (r.range_start > alloc_hint) ? {1'b0, r.range_start}
                                                        : {1'b0, alloc_hint};
                    o.status = ihht_pkg::ST_NO_FREE;
                    for (int n = 0; n <= SLOTS && cand <= last; n++) begin
                        if (lookup_slot(cand[31:0]) < 0) begin
                            o.status = insert_id(cand[31:0], r.value);
                            if (o.status == ihht_pkg::ST_OK) begin
                                o.id_out = cand[31:0];
                                bound_ids.push_back(cand[31:0]);
                                if (alloc_hint <= o.id_out)
                                    alloc_hint = (o.id_out == ihht_pkg::ID_MAX)
                                                 ? ihht_pkg::ID_MAX : o.id_out + 32'd1;
                            end
                            break;
                        end
                        cand++;
                    end
                end
            end
            ihht_pkg::K_ALLOC_EXACT: begin
                if (r.id == 0) o.status = ihht_pkg::ST_INVALID;
                else if (load_full()) o.status = ihht_pkg::ST_LOAD;
                else begin
                    o.status = insert_id(r.id, r.value);
                    if (o.status == ihht_pkg::ST_OK) bound_ids.push_back(r.id);
                end
            end
            ihht_pkg::K_FIND, ihht_pkg::K_REMOVE, ihht_pkg::K_REPLACE: begin
                if (r.id == 0) begin
                    o.status = ihht_pkg::ST_INVALID;
                end else begin
                    s = lookup_slot(r.id);
                    if (s < 0) begin
                        o.status = ihht_pkg::ST_NOT_FOUND;
                    end else begin
                        o.status    = ihht_pkg::ST_OK;
                        o.value_out = tbl_val[s];
                        if (r.kind == ihht_pkg::K_REMOVE) begin
                            tbl_state[s] = ihht_pkg::SLOT_DEAD;
                            tbl_val[s]   = '0;
                            tbl_live--;
                        end else if (r.kind == ihht_pkg::K_REPLACE) begin
                            tbl_val[s] = r.value;
                        end
                    end
                end
            end
            default: ;   // unused kinds: invalid, no state change
        endcase
        return o;
    endfunction

    function automatic ihht_pkg::t_req make_req(logic [2:0] k, logic [31:0] id,
                                                logic [31:0] rs, logic [31:0] re,
                                                logic [31:0] v);
        ihht_pkg::t_req r;
        r.kind = k; r.id = id; r.range_start = rs; r.range_end = re; r.value = v;
        return r;
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return ihht_pkg::ID_MAX;
            2: return ihht_pkg::ID_LAST;
            3: return $urandom_range(1, 200);
            default: return $urandom;
        endcase
    endfunction

    // Random request: mostly ids known to be bound (or recently bound), so
    // finds, removes and replaces hit; range windows small, open, random or at the top.
    function automatic ihht_pkg::t_req rand_req();
        logic [2:0]  k;
        logic [31:0] id;
        logic [31:0] rs;
        logic [31:0] re;
        int          p;
        p = $urandom_range(0, 99);
        if (p < 22)      k = ihht_pkg::K_ALLOC_RANGE;
        else if (p < 40) k = ihht_pkg::K_ALLOC_EXACT;
        else if (p < 60) k = ihht_pkg::K_FIND;
        else if (p < 80) k = ihht_pkg::K_REMOVE;
        else if (p < 97) k = ihht_pkg::K_REPLACE;
        else             k = 3'($urandom_range(5, 7));
        if (bound_ids.size() > 0 && $urandom_range(0, 99) < 65)
            id = bound_ids[$urandom_range(0, bound_ids.size() - 1)];
        else if ($urandom_range(0, 3) == 0)
            id = rand_word();
        else
            id = $urandom_range(1, 300);
        case ($urandom_range(0, 3))
            0: begin rs = $urandom_range(0, 400); re = rs + $urandom_range(0, 8); end
            1: begin rs = $urandom_range(0, 400); re = 0; end
            2: begin rs = $urandom; re = $urandom; end
            default: begin
                rs = ihht_pkg::ID_LAST - $urandom_range(0, 3);
                re = $urandom_range(0, 1) ? 0 : ihht_pkg::ID_MAX;
            end
        endcase
        return make_req(k, id, rs, re, $urandom);
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        errors++;
        $display("mismatch #%0d at response %0d: %s got %h expected %h",
                 errors, rsp_count, what, got, want);
    endtask

    // Driver: offers the oldest pending request; holds it until accepted.
    always @(negedge clk) begin
        if (!rst_n) begin
            req_valid <= 1'b0;
        end else if (req_valid && !req_fire) begin
            // hold payload
        end else if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= req_idle_pct) begin
            req       <= pending_reqs.pop_front();
            req_valid <= 1'b1;
        end else begin
            req_valid <= 1'b0;
        end
    end

    // Expectations are formed at acceptance, in request order.
    always @(posedge clk) begin
        req_fire <= rst_n && req_valid && req_ready;
        if (rst_n && req_valid && req_ready)
            expected_rsps.push_back(table_apply(req));
    end

    // Long receiver hold-off, counted here once started.
    always @(posedge clk) begin
        if (hold_go && hold_cnt < HOLD_CYC) hold_cnt <= hold_cnt + 1;
    end
    assign hold_rsp = hold_go && (hold_cnt < HOLD_CYC);

    always @(negedge clk) begin
        if (!rst_n) rsp_ready <= 1'b0;
        else rsp_ready <= !hold_rsp && ($urandom_range(0, 99) >= rsp_idle_pct);
    end

    // Monitor: compares each response transaction with the oldest expectation.
    always @(posedge clk) begin
        ihht_pkg::t_rsp want;
        if (rst_n && rsp_valid && rsp_ready) begin
            rsp_count++;
            if (expected_rsps.size() == 0) begin
                report_mismatch("unexpected response status", 32'(rsp.status), 32'd0);
            end else begin
                want = expected_rsps.pop_front();
                status_seen[want.status]++;
                if (rsp.status !== want.status)
                    report_mismatch("status", 32'(rsp.status), 32'(want.status));
                if (rsp.id_out !== want.id_out)
                    report_mismatch("id_out", rsp.id_out, want.id_out);
                if (rsp.value_out !== want.value_out)
                    report_mismatch("value_out", rsp.value_out, want.value_out);
            end
        end
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT_CYC) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAILURE");
            $finish;
        end
    end

    task automatic drain();
        while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0)
            @(posedge clk);
    endtask

    initial begin
        req_idle_pct = 30;
        rsp_idle_pct = 81;
        rst_n        = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        // Directed corners: invalid id, unused kinds, missing ids, extremes.
        pending_reqs.push_back(make_req(ihht_pkg::K_FIND, 32'd0, 0, 0, 0));
        pending_reqs.push_back(make_req(ihht_pkg::K_REMOVE, 32'd0, 0, 0, 0));
        pending_reqs.push_back(make_req(ihht_pkg::K_REPLACE, 32'd0, 0, 0, 1));
        pending_reqs.push_back(make_req(ihht_pkg::K_ALLOC_EXACT, 32'd0, 0, 0, 1));
        pending_reqs.push_back(make_req(3'd5, 32'd7, 0, 0, 1));
        pending_reqs.push_back(make_req(3'd7, ihht_pkg::ID_MAX, ihht_pkg::ID_MAX,
                                        ihht_pkg::ID_MAX, ihht_pkg::ID_MAX));
        pending_reqs.push_back(make_req(ihht_pkg::K_FIND, 32'd5, 0, 0, 0));
        pending_reqs.push_back(make_req(ihht_pkg::K_ALLOC_RANGE, 0, 0, 0, 32'hA5A5_A5A5));
        // empty range
        pending_reqs.push_back(make_req(ihht_pkg::K_ALLOC_RANGE, 0, 32'd10, 32'd10, 1));
        pending_reqs.push_back(make_req(ihht_pkg::K_ALLOC_RANGE, 0, 32'd10, 32'd12,
                                        ihht_pkg::ID_MAX));
        pending_reqs.push_back(make_req(ihht_pkg::K_ALLOC_EXACT, ihht_pkg::ID_MAX, 0, 0,
                                        32'h5A5A_5A5A));
        // already bound
        pending_reqs.push_back(make_req(ihht_pkg::K_ALLOC_EXACT, ihht_pkg::ID_MAX, 0, 0, 0));
        pending_reqs.push_back(make_req(ihht_pkg::K_FIND, ihht_pkg::ID_MAX, 0, 0, 0));
        pending_reqs.push_back(make_req(ihht_pkg::K_REPLACE, ihht_pkg::ID_MAX, 0, 0,
                                        32'hFFFF_0000));
        pending_reqs.push_back(make_req(ihht_pkg::K_REMOVE, ihht_pkg::ID_MAX, 0, 0, 0));
        // walk past the tombstone
        pending_reqs.push_back(make_req(ihht_pkg::K_FIND, ihht_pkg::ID_MAX, 0, 0, 0));
        // reuse the tombstone
        pending_reqs.push_back(make_req(ihht_pkg::K_ALLOC_EXACT, ihht_pkg::ID_MAX, 0, 0,
                                        32'd3));
        // top id, then hint at the top
        pending_reqs.push_back(make_req(ihht_pkg::K_ALLOC_RANGE, 0, ihht_pkg::ID_LAST, 0,
                                        32'd9));
        pending_reqs.push_back(make_req(ihht_pkg::K_ALLOC_RANGE, 0, 32'd1, 0, 32'd9));
        pending_reqs.push_back(make_req(ihht_pkg::K_ALLOC_RANGE, 0, 32'd1, ihht_pkg::ID_MAX,
                                        32'd9));
        // Fill past the load limit with exact allocs, then one more range alloc.
        for (int i = 0; i < 50; i++)
            pending_reqs.push_back(make_req(ihht_pkg::K_ALLOC_EXACT, 32'(1000 + i * 64),
                                            0, 0, $urandom));
        pending_reqs.push_back(make_req(ihht_pkg::K_ALLOC_RANGE, 0, 0, 0, 1));
        drain();

        // Random phases: idling patterns swapped between the first two, none in the third.
        for (int ph = 0; ph < 3; ph++) begin
            req_idle_pct = (ph == 0) ? 30 : (ph == 1) ? 81 : 0;
            rsp_idle_pct = (ph == 0) ? 81 : (ph == 1) ? 30 : 0;
            for (int i = 0; i < 500; i++) begin
                pending_reqs.push_back(rand_req());
                if (pending_reqs.size() > 8) @(posedge clk);
                while (pending_reqs.size() > 8) @(posedge clk);
            end
            if (ph == 1) begin
                // Receiver holds off while requests keep coming.
                hold_go = 1'b1;
                for (int i = 0; i < 6; i++) pending_reqs.push_back(rand_req());
                wait (hold_cnt == HOLD_CYC);
            end
            drain();
        end

        repeat (300) @(posedge clk);
        $display("covered %0d responses: ok %0d, bound %0d, load %0d, no-free %0d,",
                 rsp_count, status_seen[ihht_pkg::ST_OK], status_seen[ihht_pkg::ST_BOUND],
                 status_seen[ihht_pkg::ST_LOAD], status_seen[ihht_pkg::ST_NO_FREE]);
        $display("invalid %0d, not-found %0d; %0d mismatches",
                 status_seen[ihht_pkg::ST_INVALID], status_seen[ihht_pkg::ST_NOT_FOUND],
                 errors);
        if (errors == 0 && expected_rsps.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
